@@ src/mss_pkg.sv @@
// Shared constants and types of the multibyte substring search block.
package mss_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int POSITION_BITS = 16;

  localparam int OFFSET_W  = 16;
  localparam int WIDE_W    = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;
  localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
  localparam int LEN_REG_W = 5;
  localparam int RANGE_W   = 16;
  localparam int DATA_W    = 64;
  localparam int PADDR_W   = 6;
  localparam int REG_IDX_W = 3;

  // Register indexes, at byte address 8 * index.
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LEAD_RANGE_A   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LEAD_RANGE_B   = 3'd4;

  localparam logic [RANGE_W-1:0] LEAD_RANGE_A_RST = 16'h819F;
  localparam logic [RANGE_W-1:0] LEAD_RANGE_B_RST = 16'hE0FC;

  typedef logic [7:0] byte_t;

  // Configuration as seen by the search datapath.
  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] pat;
    logic [LEN_W-1:0]            len;
    logic [RANGE_W-1:0]          range_a;
    logic [RANGE_W-1:0]          range_b;
  } cfg_t;

  // Per-cycle control of the cell row.
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctl_t;

endpackage

@@ src/mss_cell.sv @@
// One cell of the shift-and row: holds one partial-match bit.
module mss_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  mss_pkg::cell_ctl_t ctl,
  input  mss_pkg::byte_t     data_byte,
  input  mss_pkg::byte_t     pat_byte,
  input  logic               enable,
  input  logic               match_in,
  output logic               match_r,
  output logic               hit
);
  import mss_pkg::*;

  logic match_nxt;

  // The bit survives only if the previous prefix matched and this pattern byte matches too.
  assign hit = match_in & enable & (pat_byte == data_byte);

  always_comb begin
    match_nxt = match_r;
    if (ctl.clear) begin
      match_nxt = 1'b0;
    end else if (ctl.advance) begin
      match_nxt = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

endmodule

@@ src/mss_regs.sv @@
// Configuration registers and their APB-style access port.
module mss_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mss_pkg::PADDR_W-1:0]   paddr,
  input  logic [mss_pkg::DATA_W-1:0]    pwdata,
  output logic [mss_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output mss_pkg::cfg_t                 cfg
);
  import mss_pkg::*;

  logic [DATA_W-1:0]    pattern_low_r, pattern_low_nxt;
  logic [DATA_W-1:0]    pattern_high_r, pattern_high_nxt;
  logic [LEN_REG_W-1:0] pattern_length_r, pattern_length_nxt;
  logic [RANGE_W-1:0]   lead_range_a_r, lead_range_a_nxt;
  logic [RANGE_W-1:0]   lead_range_b_r, lead_range_b_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic [2*DATA_W-1:0]  pattern_all;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    pattern_low_nxt    = pattern_low_r;
    pattern_high_nxt   = pattern_high_r;
    pattern_length_nxt = pattern_length_r;
    lead_range_a_nxt   = lead_range_a_r;
    lead_range_b_nxt   = lead_range_b_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_LOW:    pattern_low_nxt    = pwdata;
        REG_PATTERN_HIGH:   pattern_high_nxt   = pwdata;
        REG_PATTERN_LENGTH: pattern_length_nxt = pwdata[LEN_REG_W-1:0];
        REG_LEAD_RANGE_A:   lead_range_a_nxt   = pwdata[RANGE_W-1:0];
        REG_LEAD_RANGE_B:   lead_range_b_nxt   = pwdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= '0;
      lead_range_a_r   <= LEAD_RANGE_A_RST;
      lead_range_b_r   <= LEAD_RANGE_B_RST;
    end else begin
      pattern_low_r    <= pattern_low_nxt;
      pattern_high_r   <= pattern_high_nxt;
      pattern_length_r <= pattern_length_nxt;
      lead_range_a_r   <= lead_range_a_nxt;
      lead_range_b_r   <= lead_range_b_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_LOW:    prdata = pattern_low_r;
      REG_PATTERN_HIGH:   prdata = pattern_high_r;
      REG_PATTERN_LENGTH: prdata = {{(DATA_W-LEN_REG_W){1'b0}}, pattern_length_r};
      REG_LEAD_RANGE_A:   prdata = {{(DATA_W-RANGE_W){1'b0}}, lead_range_a_r};
      REG_LEAD_RANGE_B:   prdata = {{(DATA_W-RANGE_W){1'b0}}, lead_range_b_r};
      default:            prdata = '0;
    endcase
  end

  // Lengths above the row size are clamped to the row size.
  assign pattern_all = {pattern_high_r, pattern_low_r};
  assign cfg.pat     = pattern_all[PATTERN_MAX*8-1:0];
  assign cfg.len     = (pattern_length_r > LEN_REG_W'(PATTERN_MAX)) ?
                       LEN_W'(PATTERN_MAX) : LEN_W'(pattern_length_r);
  assign cfg.range_a = lead_range_a_r;
  assign cfg.range_b = lead_range_b_r;

endmodule

@@ src/multibyte_substring_search.sv @@
// Top level of the multibyte substring search: control, cell row and result buffer.
//
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_data_byte
// out_      output     out_valid/out_stall out_found, out_match_offset, out_overflow
// cfg       input      psel/penable/pready paddr, pwdata, prdata
//
// The cell row updates the whole shift-and vector in the cycle that a text byte is
// taken, so a byte may be accepted on every clock edge while in_stall is low.
// A result is registered into the output register, or into the skid entry while the output register still holds.
// A two-entry result buffer (output register plus skid entry) lets input bytes
// keep flowing while a result waits; in_stall rises only when both entries hold.
// Reset clears the match state and loads the default lead byte ranges.
module multibyte_substring_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_found,
  output logic [mss_pkg::OFFSET_W-1:0]     out_match_offset,
  output logic                             out_overflow,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mss_pkg::PADDR_W-1:0]      paddr,
  input  logic [mss_pkg::DATA_W-1:0]       pwdata,
  output logic [mss_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import mss_pkg::*;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
    logic                overflow;
  } result_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  cfg_t cfg;

  mss_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Per-text state.
  logic                     trail_r, trail_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     reported_r, reported_nxt;
  logic                     ovf_r, ovf_nxt;

  logic      accept;
  logic      is_term;
  logic      advance;
  logic      boundary;
  logic      lead_a;
  logic      lead_b;
  cell_ctl_t cell_ctl;

  logic [PATTERN_MAX-1:0] cell_match;
  logic [PATTERN_MAX-1:0] cell_hit;
  logic [PATTERN_MAX-1:0] cell_en;
  logic [PATTERN_MAX-1:0] last_mask;
  logic                   full_hit;

  logic [POSITION_BITS-1:0] start_pos;
  logic [WIDE_W-1:0]        start_wide;
  logic [POSITION_BITS-1:0] len_m1;

  logic    push;
  result_t push_data;

  assign accept  = in_valid & ~in_stall;
  assign is_term = (in_data_byte == 8'd0);
  assign advance = accept & ~is_term & ~reported_r;

  assign cell_ctl.advance = advance;
  assign cell_ctl.clear   = accept & is_term;

  // A byte in either lead range makes the next byte a trail byte; a trail byte
  // never starts a match and never marks the byte after it.
  assign lead_a   = (in_data_byte >= cfg.range_a[15:8]) & (in_data_byte <= cfg.range_a[7:0]);
  assign lead_b   = (in_data_byte >= cfg.range_b[15:8]) & (in_data_byte <= cfg.range_b[7:0]);
  assign boundary = ~trail_r;

  always_comb begin
    trail_nxt    = trail_r;
    pos_nxt      = pos_r;
    reported_nxt = reported_r;
    ovf_nxt      = ovf_r;
    if (accept && is_term) begin
      trail_nxt    = 1'b0;
      pos_nxt      = '0;
      reported_nxt = 1'b0;
      ovf_nxt      = 1'b0;
    end else if (advance) begin
      // The position saturates; a byte arriving at the maximum flags overflow.
      if (pos_r == POS_MAX) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + POSITION_BITS'(1);
      end
      trail_nxt = trail_r ? 1'b0 : (lead_a | lead_b);
      if ((cfg.len == '0) || full_hit) begin
        reported_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trail_r    <= 1'b0;
      pos_r      <= '0;
      reported_r <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      trail_r    <= trail_nxt;
      pos_r      <= pos_nxt;
      reported_r <= reported_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // The cell row: cell i holds "pattern bytes 0..i match ending at the last byte".
  // Cell 0 is seeded with the boundary flag, every other cell with its left neighbor.
  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
      assign cell_en[gi]   = (LEN_W'(gi) < cfg.len);
      assign last_mask[gi] = (LEN_W'(gi + 1) == cfg.len);
      if (gi == 0) begin : g_head
        mss_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctl       (cell_ctl),
          .data_byte (in_data_byte),
          .pat_byte  (cfg.pat[gi]),
          .enable    (cell_en[gi]),
          .match_in  (boundary),
          .match_r   (cell_match[gi]),
          .hit       (cell_hit[gi])
        );
      end else begin : g_body
        mss_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctl       (cell_ctl),
          .data_byte (in_data_byte),
          .pat_byte  (cfg.pat[gi]),
          .enable    (cell_en[gi]),
          .match_in  (cell_match[gi-1]),
          .match_r   (cell_match[gi]),
          .hit       (cell_hit[gi])
        );
      end
    end
  endgenerate

  // The whole pattern matches when the cell at the last pattern byte hits.
  assign full_hit = |(cell_hit & last_mask);

  // Match start is the current offset minus (length - 1), floored at zero.
  assign len_m1     = POSITION_BITS'(cfg.len) - POSITION_BITS'(1);
  assign start_pos  = (pos_r >= len_m1) ? (pos_r - len_m1) : '0;
  assign start_wide = WIDE_W'(start_pos);

  always_comb begin
    push               = 1'b0;
    push_data.found    = 1'b0;
    push_data.offset   = '0;
    push_data.overflow = ovf_nxt;
    if (accept && is_term) begin
      push               = ~reported_r;
      push_data.overflow = ovf_r;
    end else if (advance) begin
      if (cfg.len == '0) begin
        push            = 1'b1;
        push_data.found = 1'b1;
      end else if (full_hit) begin
        push             = 1'b1;
        push_data.found  = 1'b1;
        push_data.offset = start_wide[OFFSET_W-1:0];
      end
    end
  end

  // Result buffer: output register and one skid entry. The input stalls only
  // while the skid entry is occupied, so no push can be lost.
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  assign pop = out_valid_r & ~out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_stall         = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_found        = out_data_r.found;
  assign out_match_offset = out_data_r.offset;
  assign out_overflow     = out_data_r.overflow;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the multibyte substring search block.
`timescale 1ns / 100ps

module tb_top;
  import mss_pkg::*;

  // Timing and run-length knobs. The timeout leaves a wide margin over the
  // slowest legal run: some 1550 text bytes under heavy sender gaps and
  // receiver stalls, one long receiver hold-off and the register writes.
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_LIMIT    = 20_000;
  localparam int PHASE_BYTES    = 175;
  localparam int PHASE_COUNT    = 8;
  localparam int REG_COUNT      = 5;

  localparam byte_t TEXT_END = 8'h00;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // One result item of the block.
  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
    logic                overflow;
  } search_result_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [7:0]          in_data_byte = 8'h00;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic                out_found;
  logic [OFFSET_W-1:0] out_match_offset;
  logic                out_overflow;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [PADDR_W-1:0]  paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  multibyte_substring_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .out_overflow     (out_overflow),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Text bytes waiting to be offered, and results the search should still give.
  byte_t          text_bytes[$];
  search_result_t expected_results[$];

  // Traffic shaping, set by the sequence between phases.
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  bit          backpressure_req  = 1'b0;
  int unsigned backpressure_left = 0;

  bit took_item = 1'b0;
  int err_count = 0;

  // Our own copy of the configuration registers.
  logic [63:0]        cfg_pat_lo  = '0;
  logic [63:0]        cfg_pat_hi  = '0;
  logic [LEN_REG_W-1:0] cfg_len   = '0;
  logic [RANGE_W-1:0] cfg_range_a = LEAD_RANGE_A_RST;
  logic [RANGE_W-1:0] cfg_range_b = LEAD_RANGE_B_RST;

  // Search state as the block should hold it: the shift-and vector of partial
  // matches, whether the next byte is a trail byte, the saturating offset of the
  // next byte, and whether this text already gave its result.
  logic [PATTERN_MAX-1:0]   pm_vec        = '0;
  logic                     trail_next    = 1'b0;
  logic [POSITION_BITS-1:0] text_pos      = '0;
  logic                     reported      = 1'b0;
  logic                     pos_saturated = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Pattern length in use; register values above the maximum act as the maximum.
  function automatic int eff_len();
    return (cfg_len > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_len);
  endfunction

  function automatic byte_t pattern_byte(input int i);
    return (i < 8) ? cfg_pat_lo[8*i +: 8] : cfg_pat_hi[8*(i-8) +: 8];
  endfunction

  // A range is packed as first byte in the high half, last byte in the low half;
  // it is empty when first exceeds last.
  function automatic bit is_lead(input logic [RANGE_W-1:0] r, input byte_t b);
    return (r[15:8] <= r[7:0]) && (b >= r[15:8]) && (b <= r[7:0]);
  endfunction

  // Applies one text byte to the local search state and queues the result it
  // causes, if any. The terminator always clears the text state; it gives a
  // not-found result only if no match was reported for this text.
  task automatic scan_byte(input byte_t b);
    search_result_t r;
    logic [POSITION_BITS-1:0] pos;
    logic [PATTERN_MAX-1:0] eq;
    logic boundary;
    int len;
    int start;
    len = eff_len();
    if (b == TEXT_END) begin
      if (!reported) begin
        r.found = 1'b0;
        r.offset = '0;
        r.overflow = pos_saturated;
        expected_results.push_back(r);
      end
      pm_vec = '0;
      trail_next = 1'b0;
      text_pos = '0;
      reported = 1'b0;
      pos_saturated = 1'b0;
      return;
    end
    if (reported) return;

    // A byte that arrives with the counter at its top is the overflow point;
    // it and every later byte share the top offset.
    pos = text_pos;
    if (text_pos == POS_MAX) pos_saturated = 1'b1;
    else text_pos = text_pos + POSITION_BITS'(1);

    boundary = !trail_next;
    if (trail_next) trail_next = 1'b0;
    else if (is_lead(cfg_range_a, b) || is_lead(cfg_range_b, b)) trail_next = 1'b1;

    if (len == 0) begin
      reported = 1'b1;
      r.found = 1'b1;
      r.offset = '0;
      r.overflow = pos_saturated;
      expected_results.push_back(r);
      return;
    end

    eq = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < len && pattern_byte(i) == b) eq[i] = 1'b1;
    end
    pm_vec = ((pm_vec << 1) | PATTERN_MAX'(boundary)) & eq;

    if (pm_vec[len-1]) begin
      start = (int'(pos) >= len - 1) ? int'(pos) - (len - 1) : 0;
      reported = 1'b1;
      r.found = 1'b1;
      r.offset = OFFSET_W'(start);
      r.overflow = pos_saturated;
      expected_results.push_back(r);
    end
  endtask

  task automatic check_result();
    search_result_t want;
    if (expected_results.size() == 0) begin
      flag_error($sformatf("unexpected result found=%0b offset=%0d overflow=%0b",
                           out_found, out_match_offset, out_overflow));
      return;
    end
    want = expected_results.pop_front();
    if (out_found !== want.found)
      flag_error($sformatf("found is %0b, should be %0b", out_found, want.found));
    if (out_match_offset !== want.offset)
      flag_error($sformatf("match_offset is %0d, should be %0d", out_match_offset, want.offset));
    if (out_overflow !== want.overflow)
      flag_error($sformatf("overflow is %0b, should be %0b", out_overflow, want.overflow));
  endtask

  // Monitor: everything is sampled at the rising edge. Results are checked
  // before the accepted byte is applied; a result is registered in the block
  // before it reaches the output, so its expectation is already queued.
  always @(posedge clk) begin
    took_item = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        scan_byte(in_data_byte);
        took_item = 1'b1;
      end
    end
  end

  // Sender: a byte once offered stays put until taken; otherwise the next
  // byte goes out unless a random gap is drawn.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_item) begin
      if (text_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_data_byte <= text_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request, counted here,
  // during which the result buffer fills and the block must stall its input.
  always @(negedge clk) begin
    if (backpressure_req) begin
      backpressure_left = HOLD_CYCLES;
      backpressure_req = 1'b0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (backpressure_left != 0) begin
      out_stall <= 1'b1;
      backpressure_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic apply_register(input logic [REG_IDX_W-1:0] idx, input logic [63:0] v);
    case (idx)
      REG_PATTERN_LOW:    cfg_pat_lo = v;
      REG_PATTERN_HIGH:   cfg_pat_hi = v;
      REG_PATTERN_LENGTH: cfg_len = v[LEN_REG_W-1:0];
      REG_LEAD_RANGE_A:   cfg_range_a = v[RANGE_W-1:0];
      REG_LEAD_RANGE_B:   cfg_range_b = v[RANGE_W-1:0];
      default: ;
    endcase
  endtask

  // Register write: setup phase, then access phase; it lands at the edge where
  // the access phase meets pready.
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(idx, v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every byte is taken and every result has come, then for the
  // settle period in case the last text is still being worked on.
  task automatic settle_idle();
    while (text_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [RANGE_W-1:0] pick_range(input logic [RANGE_W-1:0] dflt);
    logic [7:0] a, b;
    a = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(0, 7))
      0, 1: return dflt;
      2:    return 16'h00FF;    // every byte is a lead byte
      3:    return 16'hFF00;    // empty
      4:    return 16'hFFFF;
      5:    return {a, b};
      default: return (a <= b) ? {a, b} : {b, a};
    endcase
  endfunction

  // New pattern, length and lead ranges. Unused upper bits of the narrow
  // registers carry random data as well.
  task automatic scramble_config();
    logic [63:0] lo, hi, len_v, ra_v, rb_v;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    len_v = {$urandom, $urandom};
    ra_v = {$urandom, $urandom};
    rb_v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: begin
        lo = '1;
        hi = '1;
      end
      1: begin
        lo = '0;
        hi = '0;
      end
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       len_v[4:0] = 5'd0;
      1:       len_v[4:0] = 5'd16;
      2:       len_v[4:0] = 5'($urandom_range(17, 31));
      default: len_v[4:0] = 5'($urandom_range(1, 6));
    endcase
    ra_v[15:0] = pick_range(LEAD_RANGE_A_RST);
    rb_v[15:0] = pick_range(LEAD_RANGE_B_RST);
    cfg_write(REG_PATTERN_LOW, lo);
    cfg_write(REG_PATTERN_HIGH, hi);
    cfg_write(REG_PATTERN_LENGTH, len_v);
    cfg_write(REG_LEAD_RANGE_A, ra_v);
    cfg_write(REG_LEAD_RANGE_B, rb_v);
  endtask

  function automatic byte_t lead_byte();
    byte_t b;
    if (cfg_range_a[15:8] <= cfg_range_a[7:0])
      b = 8'($urandom_range(cfg_range_a[15:8], cfg_range_a[7:0]));
    else
      b = 8'($urandom_range(1, 255));
    return (b == TEXT_END) ? 8'h01 : b;
  endfunction

  function automatic byte_t text_byte();
    byte_t b;
    int len;
    len = eff_len();
    case ($urandom_range(0, 5))
      0, 1: b = (len != 0) ? pattern_byte($urandom_range(0, len - 1)) : 8'h01;
      2:    b = lead_byte();
      default: b = 8'($urandom_range(1, 255));
    endcase
    return (b == TEXT_END) ? 8'h01 : b;
  endfunction

  // One short text: mostly whole copies of the pattern in random filler, some
  // shifted onto a trail byte by a lead byte, some cut short. Returns the
  // number of bytes queued, terminator included.
  function automatic int push_random_text();
    int n, pushed, len, k;
    byte_t b;
    len = eff_len();
    n = $urandom_range(0, 20);
    pushed = 0;
    while (pushed < n) begin
      if (len != 0 && $urandom_range(0, 2) == 0) begin
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len;
        if ($urandom_range(0, 3) == 0) begin
          text_bytes.push_back(lead_byte());
          pushed++;
        end
        for (int i = 0; i < k; i++) begin
          b = pattern_byte(i);
          text_bytes.push_back((b == TEXT_END) ? 8'h01 : b);
          pushed++;
        end
      end else begin
        text_bytes.push_back(text_byte());
        pushed++;
      end
    end
    text_bytes.push_back(TEXT_END);
    return pushed + 1;
  endfunction

  initial begin : main_seq
    int budget;
    int spins;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration has an empty pattern: an empty text is not found,
    // a non-empty one matches at offset zero and its later bytes are ignored.
    text_bytes.push_back(TEXT_END);
    text_bytes.push_back(8'hFF);
    text_bytes.push_back(8'h01);
    text_bytes.push_back(TEXT_END);
    settle_idle();

    // Pattern "ab" with the default ranges. The first "a" follows a lead byte
    // and is a trail byte, so the match starts at the second "a". A lead byte
    // right before the terminator must not leak into the next text.
    cfg_write(REG_PATTERN_LOW, 64'h6261);
    cfg_write(REG_PATTERN_LENGTH, 64'd2);
    @(posedge clk);
    text_bytes.push_back(8'h81);
    text_bytes.push_back(8'h61);
    text_bytes.push_back(8'h62);
    text_bytes.push_back(8'h61);
    text_bytes.push_back(8'h62);
    text_bytes.push_back(8'hFF);
    text_bytes.push_back(TEXT_END);
    text_bytes.push_back(8'hE0);
    text_bytes.push_back(TEXT_END);
    text_bytes.push_back(8'h61);
    text_bytes.push_back(8'h62);
    text_bytes.push_back(TEXT_END);
    settle_idle();

    // An empty first range and a range holding only zero: no lead bytes at all.
    cfg_write(REG_LEAD_RANGE_A, 64'hFF00);
    cfg_write(REG_LEAD_RANGE_B, 64'h0000);
    @(posedge clk);
    text_bytes.push_back(8'h81);
    text_bytes.push_back(8'h61);
    text_bytes.push_back(8'h62);
    text_bytes.push_back(TEXT_END);
    settle_idle();

    // A length above the maximum acts as a full 16-byte pattern.
    cfg_write(REG_PATTERN_LOW, '1);
    cfg_write(REG_PATTERN_HIGH, '1);
    cfg_write(REG_PATTERN_LENGTH, 64'd31);
    @(posedge clk);
    for (int i = 0; i < PATTERN_MAX; i++) text_bytes.push_back(8'hFF);
    text_bytes.push_back(TEXT_END);
    settle_idle();

    // Writes to addresses past the last register must change nothing.
    for (int r = REG_COUNT; r < (1 << REG_IDX_W); r++)
      cfg_write(REG_IDX_W'(r), {$urandom, $urandom});

    // Random phases: two per traffic setting, each with its own configuration.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle_idle();
      case (ph / 2)
        0: begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_gap_pct = 61;
          stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct = 61;
        end
        default: begin
          send_gap_pct = 26;
          stall_pct = 26;
        end
      endcase
      scramble_config();
      @(posedge clk);
      // Once, a long receiver hold-off against a burst of empty texts, each of
      // which gives a result at once, so the result buffer fills.
      if (ph == 1) begin
        backpressure_req = 1'b1;
        for (int i = 0; i < 40; i++) text_bytes.push_back(TEXT_END);
      end
      budget = 0;
      while (budget < PHASE_BYTES) budget += push_random_text();
    end

    while (text_bytes.size() != 0 || in_valid) @(negedge clk);
    spins = 0;
    while (expected_results.size() != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_results.size()));

    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 4);
    $display("TIMEOUT after %0d cycles", TIMEOUT_CYCLES);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
